/* sv/lrcs_pkg.sv */
// types and constants for the least run count task scheduler
// used by lrcs_pick and least_run_count_task_scheduler; depends on nothing

package lrcs_pkg;

	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned CPU_W   = 2;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned CNT_W   = 10;
	localparam int unsigned TICK_W  = 11;
	localparam int unsigned CFG_W   = 11;

	localparam logic [TICK_W-1:0] WAKE_PERIOD_RST = 11'd1500;
	localparam logic [CNT_W-1:0]  COUNT_WRAP_RST  = 10'd1000;
	localparam logic [ID_W-1:0]   NEXT_ID_RST     = 16'd2;

	// configuration register indexes
	localparam logic CFG_WAKE_PERIOD = 1'b0;
	localparam logic CFG_COUNT_WRAP  = 1'b1;

	// request codes
	localparam logic [2:0] REQ_CREATE   = 3'd0;
	localparam logic [2:0] REQ_TEARDOWN = 3'd1;
	localparam logic [2:0] REQ_TIMER    = 3'd2;
	localparam logic [2:0] REQ_YIELD    = 3'd3;
	localparam logic [2:0] REQ_ALARM    = 3'd4;

	typedef enum logic [2:0] {
		TS_UNUSED = 3'd0,
		TS_NEW    = 3'd1,
		TS_SLEEP  = 3'd3,
		TS_WAIT   = 3'd4,
		TS_RUN    = 3'd5
	} task_st_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [SLOT_W-1:0] slot;
		logic [CPU_W-1:0]  cpu;
		logic              alarm_flag;
	} in_item_t;

	typedef struct packed {
		logic              picked_valid;
		logic [SLOT_W-1:0] picked_slot;
		logic [ID_W-1:0]   new_id;
		logic              error;
	} out_item_t;

	// control from the sequencer to the search unit
	typedef struct packed {
		logic clear;
		logic rd_en;
		logic cand;
		logic wr_en;
	} pick_ctl_t;

endpackage

/* sv/lrcs_pick.sv */
// run count memory and the shared least-count compare unit
// one slot is read and compared per cycle; depends on lrcs_pkg

module lrcs_pick #(
	parameter int unsigned NUM_TASKS = 16,
	parameter int unsigned TW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrcs_pkg::pick_ctl_t           ctl,
	input  logic [TW-1:0]                 rd_addr,
	input  logic [TW-1:0]                 wr_addr,
	input  logic [lrcs_pkg::CNT_W-1:0]    wr_data,
	output logic                          found,
	output logic [TW-1:0]                 best_slot,
	output logic [lrcs_pkg::CNT_W-1:0]    best_cnt
);

	logic [lrcs_pkg::CNT_W-1:0] cnt_mem [NUM_TASKS];
	logic [lrcs_pkg::CNT_W-1:0] rd_s1;
	logic [TW-1:0]              idx_s1;
	logic                       vld_s1;
	logic                       cand_s1;
	logic                       found_q;
	logic [TW-1:0]              best_idx_q;
	logic [lrcs_pkg::CNT_W-1:0] best_cnt_q;
	logic                       better;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_s1 <= cnt_mem[rd_addr];
		end
		idx_s1  <= rd_addr;
		cand_s1 <= ctl.cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.rd_en;
		end
	end

	// strict less keeps the lowest slot on a tie
	assign better = vld_s1 && cand_s1 && (!found_q || (rd_s1 < best_cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_idx_q <= idx_s1;
			best_cnt_q <= rd_s1;
		end
	end

	assign found     = found_q;
	assign best_slot = best_idx_q;
	assign best_cnt  = best_cnt_q;

endmodule

/* sv/least_run_count_task_scheduler.sv */
// Task table scheduler for several CPUs. Create, teardown and alarm requests go from
// acceptance straight to the done state. A timer or yield trap with a valid CPU first
// updates the table in its accept cycle; the search then walks the run count memory
// one slot per cycle through a single compare unit, drains, and then dispatches the
// least-count candidate. in_stall is high for the whole time an item is in work; a
// finished result waits in the output register.
// depends on lrcs_pkg and lrcs_pick

module least_run_count_task_scheduler #(
	parameter int unsigned NUM_TASKS = 16,
	parameter int unsigned NUM_CPUS  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  lrcs_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output lrcs_pkg::out_item_t        out_item,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lrcs_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int unsigned CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DISP  = 5'b01000,
		ST_DONE  = 5'b10000
	} fsm_t;

	fsm_t state_q;

	logic [lrcs_pkg::TICK_W-1:0] wake_period_q;
	logic [lrcs_pkg::CNT_W-1:0]  count_wrap_q;
	logic [lrcs_pkg::TICK_W-1:0] tick_q;
	logic [lrcs_pkg::ID_W-1:0]   next_id_q;

	lrcs_pkg::task_st_t ts_q    [NUM_TASKS];
	logic               alarm_q [NUM_TASKS];
	logic               doom_q  [NUM_TASKS];
	lrcs_pkg::task_st_t ts_trap [NUM_TASKS];
	logic               al_trap [NUM_TASKS];
	logic               dm_trap [NUM_TASKS];

	logic          cur_v_q [NUM_CPUS];
	logic [TW-1:0] cur_s_q [NUM_CPUS];

	logic [TW-1:0] scan_q;
	logic [CW-1:0] cpu_q;
	lrcs_pkg::out_item_t res_q;
	lrcs_pkg::out_item_t res_acc;
	lrcs_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic                        accept;
	logic [TW-1:0]               sidx;
	logic [CW-1:0]               cidx;
	logic                        slot_ok;
	logic                        slot_used;
	logic                        cpu_ok;
	logic                        is_trap;
	logic                        is_timer;
	logic                        have;
	logic [TW-1:0]               cs;
	logic [lrcs_pkg::TICK_W-1:0] tick_inc;
	logic                        wake;
	logic                        create_ok;
	logic                        scan_last;
	logic                        out_free;

	lrcs_pkg::pick_ctl_t        pctl;
	logic [TW-1:0]              wr_addr;
	logic [lrcs_pkg::CNT_W-1:0] wr_data;
	logic                       found;
	logic [TW-1:0]              best_slot;
	logic [lrcs_pkg::CNT_W-1:0] best_cnt;
	logic [lrcs_pkg::CNT_W-1:0] cnt_next;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign sidx      = TW'(in_item.slot);
	assign cidx      = CW'(in_item.cpu);
	assign slot_ok   = (32'(in_item.slot) < NUM_TASKS);
	assign slot_used = slot_ok && (ts_q[sidx] != lrcs_pkg::TS_UNUSED);
	assign cpu_ok    = (32'(in_item.cpu) < NUM_CPUS);
	assign is_trap   = (in_item.req_type inside {lrcs_pkg::REQ_TIMER, lrcs_pkg::REQ_YIELD});
	assign is_timer  = (in_item.req_type == lrcs_pkg::REQ_TIMER);
	assign have      = cur_v_q[cidx];
	assign cs        = cur_s_q[cidx];
	assign tick_inc  = tick_q + 1'b1;
	assign wake      = is_timer && (tick_inc >= wake_period_q);
	assign create_ok = (in_item.req_type == lrcs_pkg::REQ_CREATE) && slot_ok && !slot_used;
	assign scan_last = (scan_q == TW'(NUM_TASKS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_next  = (best_cnt >= count_wrap_q) ? '0 : best_cnt + 1'b1;

	// table as a trap leaves it: park, wake, sleep, free
	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			ts_trap[i] = ts_q[i];
			al_trap[i] = alarm_q[i];
			dm_trap[i] = doom_q[i];
		end
		if (have) begin
			ts_trap[cs] = lrcs_pkg::TS_WAIT;
		end
		if (wake) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				if (ts_trap[i] == lrcs_pkg::TS_SLEEP) begin
					ts_trap[i] = lrcs_pkg::TS_WAIT;
					al_trap[i] = 1'b0;
				end
			end
		end
		if (!is_timer && have && alarm_q[cs]) begin
			ts_trap[cs] = lrcs_pkg::TS_SLEEP;
		end
		if (have && doom_q[cs]) begin
			ts_trap[cs] = lrcs_pkg::TS_UNUSED;
			al_trap[cs] = 1'b0;
			dm_trap[cs] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_period_q <= lrcs_pkg::WAKE_PERIOD_RST;
			count_wrap_q  <= lrcs_pkg::COUNT_WRAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lrcs_pkg::CFG_WAKE_PERIOD: wake_period_q <= cfg_data;
				lrcs_pkg::CFG_COUNT_WRAP: count_wrap_q <= cfg_data[lrcs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				ts_q[i]    <= lrcs_pkg::TS_UNUSED;
				alarm_q[i] <= 1'b0;
				doom_q[i]  <= 1'b0;
			end
		end else if (accept) begin
			case (in_item.req_type)
				lrcs_pkg::REQ_CREATE: begin
					if (create_ok) begin
						ts_q[sidx]    <= lrcs_pkg::TS_NEW;
						alarm_q[sidx] <= 1'b0;
						doom_q[sidx]  <= 1'b0;
					end
				end
				lrcs_pkg::REQ_TEARDOWN: begin
					if (slot_used) begin
						doom_q[sidx] <= 1'b1;
					end
				end
				lrcs_pkg::REQ_ALARM: begin
					if (slot_used) begin
						alarm_q[sidx] <= in_item.alarm_flag;
					end
				end
				lrcs_pkg::REQ_TIMER, lrcs_pkg::REQ_YIELD: begin
					if (cpu_ok) begin
						for (int i = 0; i < NUM_TASKS; i++) begin
							ts_q[i]    <= ts_trap[i];
							alarm_q[i] <= al_trap[i];
							doom_q[i]  <= dm_trap[i];
						end
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_DISP && found) begin
			ts_q[best_slot] <= lrcs_pkg::TS_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			next_id_q <= lrcs_pkg::NEXT_ID_RST;
		end else if (accept) begin
			if (create_ok) begin
				next_id_q <= next_id_q + 1'b1;
			end
			if (is_timer && cpu_ok) begin
				tick_q <= wake ? '0 : tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				cur_v_q[i] <= 1'b0;
				cur_s_q[i] <= '0;
			end
		end else if (state_q == ST_DISP) begin
			cur_v_q[cpu_q] <= found;
			cur_s_q[cpu_q] <= found ? best_slot : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						state_q <= (is_trap && cpu_ok) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_DISP;
				ST_DISP:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields known at acceptance
	always_comb begin
		res_acc = '0;
		case (in_item.req_type)
			lrcs_pkg::REQ_CREATE: begin
				res_acc.error  = !create_ok;
				res_acc.new_id = create_ok ? next_id_q : '0;
			end
			lrcs_pkg::REQ_TEARDOWN, lrcs_pkg::REQ_ALARM: res_acc.error = !slot_used;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q <= cidx;
			res_q <= res_acc;
		end else if (state_q == ST_DISP) begin
			res_q <= '{
				picked_valid: found,
				picked_slot:  found ? lrcs_pkg::SLOT_W'(best_slot) : '0,
				new_id:       '0,
				error:        1'b0
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		pctl.clear = accept;
		pctl.rd_en = (state_q == ST_SCAN);
		pctl.cand  = (ts_q[scan_q] == lrcs_pkg::TS_NEW) || (ts_q[scan_q] == lrcs_pkg::TS_WAIT);
		pctl.wr_en = (accept && create_ok) || (state_q == ST_DISP && found);
	end

	assign wr_addr = (state_q == ST_DISP) ? best_slot : sidx;
	assign wr_data = (state_q == ST_DISP) ? cnt_next : '0;

	lrcs_pick #(
		.NUM_TASKS (NUM_TASKS),
		.TW        (TW)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pctl),
		.rd_addr   (scan_q),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.found     (found),
		.best_slot (best_slot),
		.best_cnt  (best_cnt)
	);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_trap_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_trap && cpu_ok) |=> (state_q == ST_SCAN && scan_q == '0))
		else $error("trap did not start the slot walk");

	a_pick_is_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISP && found) |->
		(ts_q[best_slot] == lrcs_pkg::TS_NEW || ts_q[best_slot] == lrcs_pkg::TS_WAIT))
		else $error("dispatched slot is not new or waiting");

	a_pick_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.picked_valid) |-> (!out_item.error && out_item.new_id == '0))
		else $error("dispatch item carries create or error fields");

endmodule

/* tb/lrcs_checker.sv */
// checker for the least run count task scheduler: keeps its own copy of the task table,
// predicts one result per accepted item and compares each accepted result in order
// depends on lrcs_pkg

module lrcs_checker #(
	parameter int unsigned NUM_TASKS = 16,
	parameter int unsigned NUM_CPUS  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  lrcs_pkg::in_item_t         in_item,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  lrcs_pkg::out_item_t        out_item,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lrcs_pkg::CFG_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending,
	output int                         n_items,
	output int                         n_picked,
	output int                         n_refused
);
	import lrcs_pkg::*;

	localparam int PRINT_CAP = 60;

	task_st_t          tstate [NUM_TASKS];
	logic [CNT_W-1:0]  rcount [NUM_TASKS];
	logic              alarm_q [NUM_TASKS];
	logic              doom_q [NUM_TASKS];
	logic              cur_ok [NUM_CPUS];
	logic [SLOT_W-1:0] cur_at [NUM_CPUS];
	logic [TICK_W-1:0] ticks;
	logic [ID_W-1:0]   id_next;
	logic [TICK_W-1:0] wake_cfg;
	logic [CNT_W-1:0]  wrap_cfg;
	out_item_t         predicted;
	out_item_t         due_results [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		// keep the log short when the block is badly off; every mismatch still counts
		if (fails < PRINT_CAP)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic step_scheduler(input in_item_t it, output out_item_t res);
		int   s;
		int   c;
		int   best;
		logic used;
		logic have;
		logic found;
		logic [SLOT_W-1:0] cs;
		s = it.slot;
		c = it.cpu;
		res = '0;
		used = (s < NUM_TASKS) && (tstate[s] != TS_UNUSED);
		case (it.req_type)
			REQ_CREATE: begin
				if (used || s >= NUM_TASKS) begin
					res.error = 1'b1;
				end else begin
					tstate[s] = TS_NEW;
					rcount[s] = '0;
					alarm_q[s] = 1'b0;
					doom_q[s] = 1'b0;
					res.new_id = id_next;
					id_next = id_next + 1'b1;
				end
			end
			REQ_TEARDOWN: begin
				if (used) doom_q[s] = 1'b1;
				else res.error = 1'b1;
			end
			REQ_ALARM: begin
				if (used) alarm_q[s] = it.alarm_flag;
				else res.error = 1'b1;
			end
			REQ_TIMER, REQ_YIELD: begin
				if (c < NUM_CPUS) begin
					have = cur_ok[c];
					cs = cur_at[c];
					if (have) tstate[cs] = TS_WAIT;
					if (it.req_type == REQ_TIMER) begin
						ticks = ticks + 1'b1;
						if (ticks >= wake_cfg) begin
							ticks = '0;
							for (int i = 0; i < NUM_TASKS; i++) begin
								if (tstate[i] == TS_SLEEP) begin
									tstate[i] = TS_WAIT;
									alarm_q[i] = 1'b0;
								end
							end
						end
					end else if (have && alarm_q[cs]) begin
						tstate[cs] = TS_SLEEP;
					end
					if (have && doom_q[cs]) begin
						tstate[cs] = TS_UNUSED;
						rcount[cs] = '0;
						alarm_q[cs] = 1'b0;
						doom_q[cs] = 1'b0;
					end
					// least run count among new and waiting tasks, lowest slot wins a tie
					found = 1'b0;
					best = 0;
					for (int i = 0; i < NUM_TASKS; i++) begin
						if (tstate[i] == TS_NEW || tstate[i] == TS_WAIT) begin
							if (!found || rcount[i] < rcount[best]) begin
								found = 1'b1;
								best = i;
							end
						end
					end
					cur_ok[c] = found;
					cur_at[c] = found ? SLOT_W'(best) : '0;
					if (found) begin
						tstate[best] = TS_RUN;
						rcount[best] = (rcount[best] >= wrap_cfg) ? '0 : rcount[best] + 1'b1;
						res.picked_valid = 1'b1;
						res.picked_slot = SLOT_W'(best);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			report_mismatch("result with nothing due, new_id", got.new_id, 0);
		end else begin
			want = due_results.pop_front();
			if (got.picked_valid !== want.picked_valid)
				report_mismatch("picked_valid", got.picked_valid, want.picked_valid);
			if (got.picked_slot !== want.picked_slot)
				report_mismatch("picked_slot", got.picked_slot, want.picked_slot);
			if (got.new_id !== want.new_id)
				report_mismatch("new_id", got.new_id, want.new_id);
			if (got.error !== want.error)
				report_mismatch("error", got.error, want.error);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				tstate[i] = TS_UNUSED;
				rcount[i] = '0;
				alarm_q[i] = 1'b0;
				doom_q[i] = 1'b0;
			end
			for (int i = 0; i < NUM_CPUS; i++) begin
				cur_ok[i] = 1'b0;
				cur_at[i] = '0;
			end
			ticks = '0;
			id_next = NEXT_ID_RST;
			wake_cfg = WAKE_PERIOD_RST;
			wrap_cfg = COUNT_WRAP_RST;
			due_results.delete();
			fails = 0;
			pending = 0;
			n_items = 0;
			n_picked = 0;
			n_refused = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WAKE_PERIOD) wake_cfg = cfg_data;
				else wrap_cfg = cfg_data[CNT_W-1:0];
			end
			// results leaving now belong to items taken at earlier edges
			if (out_valid && !out_stall) check_result(out_item);
			if (in_valid && !in_stall) begin
				step_scheduler(in_item, predicted);
				due_results.push_back(predicted);
				n_items++;
				if (predicted.picked_valid) n_picked++;
				if (predicted.error) n_refused++;
			end
			pending = due_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// top of the scheduler testbench: clock, reset, register writes, item stimulus with
// random idling on both channels, a watchdog and the verdict
// depends on lrcs_pkg, lrcs_checker and least_run_count_task_scheduler

module tb_top;
	import lrcs_pkg::*;

	localparam int unsigned NUM_TASKS = 16;
	localparam int unsigned NUM_CPUS  = 4;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 270;
	localparam int QUIET_LIMIT = 4000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_item;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	bit               idle_on = 1'b1;
	int               quiet;
	int               fails;
	int               pending;
	int               n_items;
	int               n_picked;
	int               n_refused;

	least_run_count_task_scheduler #(
		.NUM_TASKS(NUM_TASKS),
		.NUM_CPUS (NUM_CPUS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	lrcs_checker #(
		.NUM_TASKS(NUM_TASKS),
		.NUM_CPUS (NUM_CPUS)
	) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending),
		.n_items  (n_items),
		.n_picked (n_picked),
		.n_refused(n_refused)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// every item is followed by its result, so a hang shows up as a quiet stretch
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles with no item moving", quiet);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side backpressure in bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_item(input in_item_t it);
		logic [31:0] junk;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			junk = $urandom;
			in_valid <= 1'b0;
			in_item <= junk[$bits(in_item_t)-1:0];
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic put(input logic [2:0] req, input int slot, input int cpu, input bit flag);
		in_item_t it;
		it.req_type = req;
		it.slot = SLOT_W'(slot);
		it.cpu = CPU_W'(cpu);
		it.alarm_flag = flag;
		send_item(it);
	endtask

	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (NUM_TASKS + 8) @(negedge clk);
	endtask

	task automatic write_regs(input int wake_v, input int wrap_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WAKE_PERIOD;
		cfg_data <= CFG_W'(wake_v);
		@(negedge clk);
		cfg_index <= CFG_COUNT_WRAP;
		cfg_data <= CFG_W'(wrap_v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int n);
		in_item_t    it;
		logic [31:0] r;
		int          done;
		int          pick;
		done = 0;
		while (done < n) begin
			r = $urandom;
			it = r[$bits(in_item_t)-1:0];
			pick = $urandom_range(0, 99);
			if (pick < 18) it.req_type = REQ_CREATE;
			else if (pick < 28) it.req_type = REQ_TEARDOWN;
			else if (pick < 56) it.req_type = REQ_TIMER;
			else if (pick < 84) it.req_type = REQ_YIELD;
			else if (pick < 96) it.req_type = REQ_ALARM;
			else it.req_type = 3'($urandom_range(5, 7));
			send_item(it);
			if (pick < 96) done++;
		end
	endtask

	initial begin
		int wake_v;
		int wrap_v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_WAKE_PERIOD;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at reset register values
		put(REQ_TIMER, 0, 0, 0);     // empty table, nothing to dispatch
		put(REQ_YIELD, 15, 3, 1);
		put(REQ_CREATE, 0, 0, 0);
		put(REQ_CREATE, 15, 3, 1);
		put(REQ_CREATE, 0, 0, 0);    // slot already taken
		put(REQ_TEARDOWN, 7, 0, 0);  // unused slot
		put(REQ_ALARM, 7, 0, 1);     // unused slot
		put(3'd5, 15, 3, 1);         // unknown request types
		put(3'd6, 0, 0, 0);
		put(3'd7, 15, 3, 1);
		put(REQ_TIMER, 0, 3, 0);
		put(REQ_YIELD, 0, 3, 0);
		put(REQ_ALARM, 15, 0, 1);
		put(REQ_YIELD, 0, 3, 0);     // current task goes to sleep
		put(REQ_TIMER, 0, 1, 0);
		put(REQ_TEARDOWN, 0, 0, 0);
		put(REQ_TIMER, 0, 3, 0);     // doomed current task is freed
		put(REQ_CREATE, 0, 0, 0);
		put(REQ_ALARM, 0, 0, 1);
		put(REQ_ALARM, 0, 0, 0);
		put(REQ_CREATE, 9, 2, 0);
		put(REQ_TEARDOWN, 9, 1, 1);  // marked while not current
		put(REQ_YIELD, 0, 2, 0);
		put(REQ_TIMER, 0, 1, 0);
		put(REQ_YIELD, 0, 2, 0);
		in_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					wake_v = 1;
					wrap_v = 1;
				end
				1: begin
					wake_v = 2047;
					wrap_v = 'h7FF;  // upper data bit falls outside the count wrap field
				end
				2: begin
					wake_v = 3;
					wrap_v = 2;
				end
				3: begin
					wake_v = $urandom_range(1, 40);
					wrap_v = $urandom_range(1, 15);
				end
				4: begin
					wake_v = $urandom_range(1, 2047);
					wrap_v = $urandom_range(1, 1023);
				end
				default: begin
					wake_v = 9;
					wrap_v = 4;
				end
			endcase
			settle();
			idle_on = (ph != PHASES - 1);
			write_regs(wake_v, wrap_v);
			random_items(PHASE_ITEMS);
			in_valid <= 1'b0;
		end

		settle();
		$display("covered %0d items: %0d dispatches, %0d refused requests", n_items, n_picked,
			n_refused);
		$display("register settings spanned both ends of wake period and count wrap");
		if (fails == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches", fails);
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/lrcs_pkg.sv
sv/lrcs_pick.sv
sv/least_run_count_task_scheduler.sv
tb/lrcs_checker.sv
tb/tb_top.sv
